/* hw/rtl/ppa_pkg.sv */
`default_nettype none
package ppa_pkg;

	localparam int CoordW   = 16;                // input coordinate width
	localparam int DiffW    = CoordW + 1;        // difference / sum of two coordinates
	localparam int ProdW    = 2 * DiffW;         // signed product of two differences, or of a sum and a difference
	localparam int SqW      = ProdW;             // dx^2 + dy^2
	localparam int RootW    = SqW / 2;           // floor square root
	localparam int RemW     = RootW + 4;         // square root remainder
	localparam int SqrtSteps = SqW / 2;          // one result bit per step
	localparam int IterW    = $clog2(SqrtSteps);
	localparam int PerimW   = 23;
	localparam int AreaW    = 39;
	localparam int ShoeW    = 41;
	localparam int InDataW  = 32;
	localparam int OutDataW = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDX,
		ST_MDY,
		ST_MTERM,
		ST_START,
		ST_SQRT,
		ST_ACC,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_ACCEPT,
		STEP_MDX,
		STEP_MDY,
		STEP_MTERM,
		STEP_START,
		STEP_SQRT,
		STEP_ACC,
		STEP_EMIT
	} step_t;

	typedef struct packed {
		step_t step;
		logic  close;   // edge runs from previous vertex back to the first one
	} dp_cmd_t;

	typedef struct packed {
		logic middle;     // a vertex accepted now opens a new edge
		logic sqrt_done;  // last square root step this cycle
	} dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/ppa_ctrl.sv */
`default_nettype none
module ppa_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    in_last,
	output logic                   out_valid,
	input  wire                    out_ready,
	output ppa_pkg::dp_cmd_t       cmd,
	input  ppa_pkg::dp_status_t    status
);

	ppa_pkg::state_t state_q, state_d;
	logic close_q, close_d;
	logic last_q, last_d;
	logic out_valid_q;
	logic load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppa_pkg::ST_IDLE;
			close_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			close_q <= close_d;
			last_q  <= last_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		close_d   = close_q;
		last_d    = last_q;
		in_ready  = 1'b0;
		load_out  = 1'b0;
		cmd.step  = ppa_pkg::STEP_NONE;
		cmd.close = close_q;
		unique case (state_q)
			ppa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.step = ppa_pkg::STEP_ACCEPT;
					last_d   = in_last;
					if (status.middle) begin
						close_d = 1'b0;
						state_d = ppa_pkg::ST_MDX;
					end else if (in_last) begin
						close_d = 1'b1;
						state_d = ppa_pkg::ST_MDX;
					end
				end
			end
			ppa_pkg::ST_MDX: begin
				cmd.step = ppa_pkg::STEP_MDX;
				state_d  = ppa_pkg::ST_MDY;
			end
			ppa_pkg::ST_MDY: begin
				cmd.step = ppa_pkg::STEP_MDY;
				state_d  = ppa_pkg::ST_MTERM;
			end
			ppa_pkg::ST_MTERM: begin
				cmd.step = ppa_pkg::STEP_MTERM;
				state_d  = ppa_pkg::ST_START;
			end
			ppa_pkg::ST_START: begin
				cmd.step = ppa_pkg::STEP_START;
				state_d  = ppa_pkg::ST_SQRT;
			end
			ppa_pkg::ST_SQRT: begin
				cmd.step = ppa_pkg::STEP_SQRT;
				if (status.sqrt_done) begin
					state_d = ppa_pkg::ST_ACC;
				end
			end
			ppa_pkg::ST_ACC: begin
				cmd.step = ppa_pkg::STEP_ACC;
				if (close_q) begin
					state_d = ppa_pkg::ST_EMIT;
				end else if (last_q) begin
					// chain the closing edge
					close_d = 1'b1;
					state_d = ppa_pkg::ST_MDX;
				end else begin
					state_d = ppa_pkg::ST_IDLE;
				end
			end
			ppa_pkg::ST_EMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.step = ppa_pkg::STEP_EMIT;
					load_out = 1'b1;
					close_d  = 1'b0;
					last_d   = 1'b0;
					state_d  = ppa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppa_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* hw/rtl/ppa_dp.sv */
`default_nettype none
module ppa_dp #(
	parameter int MAX_VERTICES = 32,
	parameter int COORD_WIDTH  = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [ppa_pkg::CoordW-1:0]      in_x,
	input  wire  [ppa_pkg::CoordW-1:0]      in_y,
	input  ppa_pkg::dp_cmd_t                cmd,
	output ppa_pkg::dp_status_t             status,
	output logic [ppa_pkg::PerimW-1:0]      perimeter,
	output logic [ppa_pkg::AreaW-1:0]       area,
	output logic                            too_many_vertices
);

	localparam int CwEff = (COORD_WIDTH < ppa_pkg::CoordW) ? COORD_WIDTH : ppa_pkg::CoordW;
	localparam int ExtSh = ppa_pkg::CoordW - CwEff;
	localparam int CntW  = $clog2(MAX_VERTICES + 1);

	localparam int CW = ppa_pkg::CoordW;
	localparam int DW = ppa_pkg::DiffW;
	localparam int PW = ppa_pkg::ProdW;
	localparam int SW = ppa_pkg::ShoeW;
	localparam int RW = ppa_pkg::RootW;
	localparam int MW = ppa_pkg::RemW;
	localparam int EW = ppa_pkg::PerimW;
	localparam int AW = ppa_pkg::AreaW;

	// coordinates, sign-extended from the active width
	logic [CW-1:0]        x_sh, y_sh;
	logic signed [CW-1:0] x_in, y_in;

	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic [CntW-1:0]      count_q;
	logic                 ovf_q;
	logic signed [SW-1:0] shoe_q;
	logic [EW-1:0]        edge_q;

	logic signed [PW-1:0] prod_q;
	logic [ppa_pkg::SqW-1:0] sq_q, rad_q;
	logic [MW-1:0]        rem_q;
	logic [RW-1:0]        root_q;
	logic [ppa_pkg::IterW-1:0] iter_q;

	logic [EW-1:0]        perim_q;
	logic [AW-1:0]        area_q;
	logic                 tmv_q;

	logic signed [CW-1:0] bx, by;
	logic signed [DW-1:0] dx, dy, sx;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_d;

	logic [MW-1:0]        rem_sh, trial, rem_d;
	logic                 ge;

	logic signed [SW:0]   shoe_sum;
	logic signed [SW-1:0] shoe_d;
	logic [EW:0]          edge_sum;
	logic [EW-1:0]        edge_d;
	logic [SW-1:0]        mag;
	logic [AW:0]          half;
	logic [AW-1:0]        area_d;

	assign x_sh = in_x << ExtSh;
	assign y_sh = in_y << ExtSh;
	assign x_in = $signed(x_sh) >>> ExtSh;
	assign y_in = $signed(y_sh) >>> ExtSh;

	assign bx = cmd.close ? first_x_q : cur_x_q;
	assign by = cmd.close ? first_y_q : cur_y_q;
	assign dx = {prev_x_q[CW-1], prev_x_q} - {bx[CW-1], bx};
	assign dy = {prev_y_q[CW-1], prev_y_q} - {by[CW-1], by};
	assign sx = {prev_x_q[CW-1], prev_x_q} + {bx[CW-1], bx};

	// shared multiplier
	always_comb begin
		unique case (cmd.step)
			ppa_pkg::STEP_MDY: begin
				mul_a = dy;
				mul_b = dy;
			end
			ppa_pkg::STEP_MTERM: begin
				mul_a = sx;
				mul_b = dy;
			end
			default: begin
				mul_a = dx;
				mul_b = dx;
			end
		endcase
	end
	assign prod_d = mul_a * mul_b;

	// one root bit per step
	assign rem_sh = {rem_q[MW-3:0], rad_q[ppa_pkg::SqW-1 -: 2]};
	assign trial  = {{(MW-RW-2){1'b0}}, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign rem_d  = ge ? rem_sh - trial : rem_sh;

	assign shoe_sum = {shoe_q[SW-1], shoe_q} + {{(SW+1-PW){prod_q[PW-1]}}, prod_q};
	always_comb begin
		if (shoe_sum[SW] != shoe_sum[SW-1]) begin
			shoe_d = shoe_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			shoe_d = shoe_sum[SW-1:0];
		end
	end

	assign edge_sum = {1'b0, edge_q} + {{(EW+1-RW){1'b0}}, root_q};
	assign edge_d   = edge_sum[EW] ? {EW{1'b1}} : edge_sum[EW-1:0];

	assign mag    = shoe_q[SW-1] ? SW'(-shoe_q) : SW'(shoe_q);
	assign half   = mag[SW-1:1];
	assign area_d = half[AW] ? {AW{1'b1}} : half[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			shoe_q    <= '0;
			edge_q    <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			prod_q    <= '0;
			sq_q      <= '0;
			rad_q     <= '0;
			rem_q     <= '0;
			root_q    <= '0;
			iter_q    <= '0;
			perim_q   <= '0;
			area_q    <= '0;
			tmv_q     <= 1'b0;
		end else begin
			unique case (cmd.step)
				ppa_pkg::STEP_ACCEPT: begin
					cur_x_q <= x_in;
					cur_y_q <= y_in;
					if (count_q == '0) begin
						first_x_q <= x_in;
						first_y_q <= y_in;
						prev_x_q  <= x_in;
						prev_y_q  <= y_in;
						count_q   <= CntW'(1);
					end else if (count_q < CntW'(MAX_VERTICES)) begin
						count_q <= count_q + CntW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				ppa_pkg::STEP_MDX: begin
					prod_q <= prod_d;
				end
				ppa_pkg::STEP_MDY: begin
					prod_q <= prod_d;
					sq_q   <= prod_q;
				end
				ppa_pkg::STEP_MTERM: begin
					prod_q <= prod_d;
					sq_q   <= sq_q + prod_q;
				end
				ppa_pkg::STEP_START: begin
					shoe_q <= shoe_d;
					rad_q  <= sq_q;
					rem_q  <= '0;
					root_q <= '0;
					iter_q <= '0;
				end
				ppa_pkg::STEP_SQRT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= rem_d;
					root_q <= {root_q[RW-2:0], ge};
					iter_q <= iter_q + ppa_pkg::IterW'(1);
				end
				ppa_pkg::STEP_ACC: begin
					edge_q <= edge_d;
					if (!cmd.close) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
					end
				end
				ppa_pkg::STEP_EMIT: begin
					perim_q   <= edge_q;
					area_q    <= area_d;
					tmv_q     <= ovf_q;
					// start a new polygon
					count_q   <= '0;
					ovf_q     <= 1'b0;
					shoe_q    <= '0;
					edge_q    <= '0;
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.middle    = (count_q != '0) && (count_q < CntW'(MAX_VERTICES));
	assign status.sqrt_done = (iter_q == ppa_pkg::IterW'(ppa_pkg::SqrtSteps - 1));

	assign perimeter         = perim_q;
	assign area              = area_q;
	assign too_many_vertices = tmv_q;

endmodule
`default_nettype wire

/* hw/rtl/polygon_perimeter_and_area.sv */
// Polygon perimeter and shoelace area over a stream of vertices.
// Input stream: one vertex per transaction, s_axis_tdata = {y, x}, each a
// signed Q8.8 coordinate, s_axis_tlast set on the final vertex of a polygon.
// Output stream: one transaction per polygon, m_axis_tdata = {area, perimeter}
// (perimeter unsigned Q15.8, area unsigned Q23.16, both saturating) and
// m_axis_tuser set when the polygon had more than MAX_VERTICES vertices; the
// extra vertices are ignored, the closing edge still goes back to the first.
// Flow: the first vertex of a polygon and any vertex over the limit open no
// edge of their own, and the next vertex is accepted without a wait. Every
// other vertex opens an edge, and no vertex is taken until it is done: three
// passes through one shared 17x17 multiplier, a start step, a bit-pair square
// root and an accumulate step. The final vertex adds the closing edge as well
// (as its only edge when it is the only vertex or is over the limit), and its
// result is held back while the output register is still occupied.
// A finished result sits in the output register; the next polygon's vertices
// are accepted while the receiver stalls, and only the next result waits.
// Reset clears all sums and counters and drops any pending result.
`default_nettype none
module polygon_perimeter_and_area #(
	parameter int MAX_VERTICES = 32,
	parameter int COORD_WIDTH  = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  [ppa_pkg::InDataW-1:0]       s_axis_tdata,  // vertex_x, vertex_y
	input  wire                               s_axis_tlast,  // last_vertex
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [ppa_pkg::OutDataW-1:0]      m_axis_tdata,  // perimeter, area, zero pad
	output logic [0:0]                        m_axis_tuser   // too_many_vertices
);

	ppa_pkg::dp_cmd_t    cmd;
	ppa_pkg::dp_status_t status;

	logic [ppa_pkg::PerimW-1:0] perimeter;
	logic [ppa_pkg::AreaW-1:0]  area;
	logic                       too_many_vertices;

	ppa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	ppa_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_x              (s_axis_tdata[ppa_pkg::CoordW-1:0]),
		.in_y              (s_axis_tdata[2*ppa_pkg::CoordW-1:ppa_pkg::CoordW]),
		.cmd               (cmd),
		.status            (status),
		.perimeter         (perimeter),
		.area              (area),
		.too_many_vertices (too_many_vertices)
	);

	assign m_axis_tdata = {{(ppa_pkg::OutDataW - ppa_pkg::PerimW - ppa_pkg::AreaW){1'b0}},
		area, perimeter};
	assign m_axis_tuser = too_many_vertices;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CoordW   = ppa_pkg::CoordW;
	localparam int PerimW   = ppa_pkg::PerimW;
	localparam int AreaW    = ppa_pkg::AreaW;
	localparam int InDataW  = ppa_pkg::InDataW;
	localparam int OutDataW = ppa_pkg::OutDataW;

	localparam int MAX_VERTS   = 32;
	localparam longint PERIM_CAP  = 64'd8388607;
	localparam longint AREA_CAP   = 64'd549755813887;
	localparam longint SHOE_HIGH  = 64'sd1099511627775;
	localparam longint SHOE_LOW   = -64'sd1099511627776;
	localparam int VERTEX_TARGET = 1800;

	typedef struct {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic                     last;
		bit                       drain;  // hold until every result is back
		bit                       hurry;  // no gap after this vertex
	} vertex_t;

	typedef struct {
		logic [PerimW-1:0] perimeter;
		logic [AreaW-1:0]  area;
		logic              too_many;
	} polygon_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	wire                 s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;   // vertex_x, vertex_y
	logic                s_axis_tlast = 1'b0; // last_vertex
	wire                 m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	wire [OutDataW-1:0]  m_axis_tdata;        // perimeter, area, zero pad
	wire [0:0]           m_axis_tuser;        // too_many_vertices

	polygon_perimeter_and_area #(
		.MAX_VERTICES(MAX_VERTS),
		.COORD_WIDTH (CoordW)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	vertex_t         vertex_q[$];
	polygon_result_t polygon_due[$];
	int              owed = 0;
	int              errors = 0;
	int              tx_gap = 0;
	int              rx_wait = 0;
	bit              rx_hurry = 1'b0;

	// predictor state
	longint first_x, first_y, prev_x, prev_y;
	longint shoe_acc, perim_acc;
	int     nverts;
	bit     dropped;

	task automatic clear_polygon();
		first_x = 0;
		first_y = 0;
		prev_x = 0;
		prev_y = 0;
		shoe_acc = 0;
		perim_acc = 0;
		nverts = 0;
		dropped = 1'b0;
	endtask

	function automatic longint root_floor(longint v);
		longint r;
		longint t;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	task automatic add_side(input longint x0, input longint y0, input longint x1,
			input longint y1);
		longint dx;
		longint dy;
		dx = x0 - x1;
		dy = y0 - y1;
		perim_acc += root_floor(dx * dx + dy * dy);
		if (perim_acc > PERIM_CAP) perim_acc = PERIM_CAP;
		shoe_acc += (x0 + x1) * (y0 - y1);
		if (shoe_acc > SHOE_HIGH) shoe_acc = SHOE_HIGH;
		if (shoe_acc < SHOE_LOW) shoe_acc = SHOE_LOW;
	endtask

	task automatic take_vertex(input logic signed [CoordW-1:0] vx,
			input logic signed [CoordW-1:0] vy, input logic last,
			output bit done, output polygon_result_t res);
		longint x;
		longint y;
		longint mag;
		longint ar;
		x = vx;
		y = vy;
		done = 1'b0;
		res = '{default: '0};
		if (nverts == 0) begin
			first_x = x;
			first_y = y;
			prev_x = x;
			prev_y = y;
			nverts = 1;
		end else if (nverts < MAX_VERTS) begin
			add_side(prev_x, prev_y, x, y);
			prev_x = x;
			prev_y = y;
			nverts++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			// close back to the first vertex
			add_side(prev_x, prev_y, first_x, first_y);
			mag = shoe_acc < 0 ? -shoe_acc : shoe_acc;
			ar = mag >>> 1;
			if (ar > AREA_CAP) ar = AREA_CAP;
			res.perimeter = perim_acc[PerimW-1:0];
			res.area = ar[AreaW-1:0];
			res.too_many = dropped;
			done = 1'b1;
			clear_polygon();
		end
	endtask

	initial clear_polygon();

	// Predict on accepted vertices, check accepted results.
	always @(posedge clk) begin : scoreboard
		bit              done;
		polygon_result_t res;
		polygon_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				take_vertex(s_axis_tdata[CoordW-1:0], s_axis_tdata[2*CoordW-1:CoordW],
					s_axis_tlast, done, res);
				if (done) polygon_due.push_back(res);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (polygon_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t: unexpected result tdata=%h tuser=%b", $realtime,
							m_axis_tdata, m_axis_tuser);
				end else begin
					want = polygon_due.pop_front();
					if (m_axis_tdata[PerimW-1:0] !== want.perimeter ||
							m_axis_tdata[PerimW+AreaW-1:PerimW] !== want.area ||
							m_axis_tuser[0] !== want.too_many) begin
						errors++;
						if (errors <= 10)
							$display("%t: mismatch perimeter %0d/%0d area %0d/%0d flag %b/%b",
								$realtime, m_axis_tdata[PerimW-1:0], want.perimeter,
								m_axis_tdata[PerimW+AreaW-1:PerimW], want.area,
								m_axis_tuser[0], want.too_many);
					end
				end
			end
			owed <= polygon_due.size();
		end
	end

	// Vertex driver
	always @(posedge clk) begin : vertex_driver
		vertex_t cur;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (vertex_q.size() > 0 &&
					(!vertex_q[0].drain || (!s_axis_tvalid && owed == 0))) begin
				cur = vertex_q.pop_front();
				s_axis_tdata <= {cur.y, cur.x};
				s_axis_tlast <= cur.last;
				s_axis_tvalid <= 1'b1;
				tx_gap <= cur.hurry ? 0 : $urandom_range(0, 9);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls, counted while a result waits
	always @(posedge clk) begin : result_sink
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if ($urandom_range(0, 29) == 0) rx_hurry <= !rx_hurry;
			w = rx_hurry ? 0 : $urandom_range(0, 9);
			rx_wait <= w;
			m_axis_tready <= (w == 0);
		end else if (rx_wait > 0) begin
			if (m_axis_tvalid) begin
				rx_wait <= rx_wait - 1;
				m_axis_tready <= (rx_wait == 1);
			end
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic push_vertex(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
			input logic last, input bit drain = 1'b0, input bit hurry = 1'b0);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.last = last;
		v.drain = drain;
		v.hurry = hurry;
		vertex_q.push_back(v);
	endtask

	function automatic logic [CoordW-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int pick;
		int style;
		bit drain;
		bit hurry;
		logic [CoordW-1:0] cx;
		logic [CoordW-1:0] cy;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;

		// single vertex: zero perimeter and area
		push_vertex(16'h7fff, 16'h8000, 1'b1);
		// two vertices: twice the diagonal
		push_vertex(16'h8000, 16'h8000, 1'b0);
		push_vertex(16'h7fff, 16'h7fff, 1'b1);
		// triangle across the full range
		push_vertex(16'h8000, 16'h8000, 1'b0);
		push_vertex(16'h7fff, 16'h8000, 1'b0);
		push_vertex(16'h8000, 16'h7fff, 1'b1);
		// full-range square, clockwise, after draining
		push_vertex(16'h8000, 16'h8000, 1'b0, 1'b1);
		push_vertex(16'h8000, 16'h7fff, 1'b0);
		push_vertex(16'h7fff, 16'h7fff, 1'b0);
		push_vertex(16'h7fff, 16'h8000, 1'b1);
		// collinear points
		push_vertex(16'h0000, 16'h0000, 1'b0);
		push_vertex(16'h0100, 16'h0100, 1'b0);
		push_vertex(16'h0200, 16'h0200, 1'b1);
		// small quadrilateral, three corners of a unit square and one just below the origin, counterclockwise, back to back
		push_vertex(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		push_vertex(16'h0100, 16'h0000, 1'b0, 1'b0, 1'b1);
		push_vertex(16'h0100, 16'h0100, 1'b0, 1'b0, 1'b1);
		push_vertex(16'hffff, 16'hffff, 1'b1, 1'b0, 1'b1);

		while (vertex_q.size() < VERTEX_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) n = $urandom_range(1, 2);
			else if (pick < 78) n = $urandom_range(3, 12);
			else if (pick < 88) n = $urandom_range(13, 31);
			else n = $urandom_range(32, 40);  // at and over the vertex limit
			style = $urandom_range(0, 2);
			drain = ($urandom_range(0, 19) == 0);
			hurry = ($urandom_range(0, 5) == 0);
			cx = CoordW'($urandom);
			cy = CoordW'($urandom);
			for (int i = 0; i < n; i++) begin
				case (style)
					0: begin
						x = CoordW'($urandom);
						y = CoordW'($urandom);
					end
					1: begin
						x = CoordW'(cx + $urandom_range(0, 1023) - 512);
						y = CoordW'(cy + $urandom_range(0, 1023) - 512);
					end
					default: begin
						x = corner_value();
						y = corner_value();
					end
				endcase
				push_vertex(x, y, i == n - 1, drain && i == 0, hurry);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (vertex_q.size() > 0 || s_axis_tvalid) @(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && polygon_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#8ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_ctrl.sv
hw/rtl/ppa_dp.sv
hw/rtl/polygon_perimeter_and_area.sv
tb/testbench.sv
